>>> rtl/tlsdf_pkg.sv
// tlsdf_pkg: constants and types for the tls record deframer
// no dependencies
`default_nettype none

package tlsdf_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam logic [15:0] MaxLenReset = 16'd16384;
  localparam logic [7:0]  VerMajor    = 8'h03;
  localparam logic [7:0]  VerMinorLo  = 8'h01;
  localparam logic [7:0]  VerMinorHi  = 8'h04;

  typedef enum logic [6:0] {
    ST_TYPE    = 7'b0000001,
    ST_VER_HI  = 7'b0000010,
    ST_VER_LO  = 7'b0000100,
    ST_LEN_HI  = 7'b0001000,
    ST_LEN_LO  = 7'b0010000,
    ST_PAYLOAD = 7'b0100000,
    ST_FAILED  = 7'b1000000
  } dfr_state_t;

endpackage

`default_nettype wire

>>> rtl/tls_record_deframer_unit.sv
// tls_record_deframer_unit: tls record header parser and fragment byte tagger
// depends on tlsdf_pkg
// result valid the cycle after its byte is taken; one byte per cycle unless out_ready stalls
// the result register drains while the next byte is taken (in_ready = !out_valid | out_ready)
// headers take five bytes; version and length are checked by compares, payload tracked by a 16-bit count
// reset (synchronous, rst_n low) clears state to header start and max length to 16384
`default_nettype none

module tls_record_deframer_unit
  import tlsdf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [7:0]          out_record_type,
  output logic      [7:0]          out_data_byte,
  output logic                     out_has_data,
  output logic                     out_last_of_record,
  output logic                     out_header_error
);

  dfr_state_t  state_r, state_nxt;
  logic [15:0] max_len_r;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  ver_hi_r, ver_hi_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic        out_valid_r;
  logic [7:0]  out_type_r, out_data_r;
  logic        out_has_r, out_last_r, out_err_r;
  logic        res_vld;
  logic [7:0]  res_data;
  logic        res_has, res_last, res_err;
  logic        in_fire;
  logic [15:0] hdr_len;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[CfgAddrW-1] == 1'b0);
  assign prdata  = reg_sel ? {16'd0, max_len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MaxLenReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_len_r <= pwdata[15:0];
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign hdr_len  = {len_hi_r, in_byte};

  always_comb begin
    state_nxt  = state_r;
    type_nxt   = type_r;
    ver_hi_nxt = ver_hi_r;
    len_hi_nxt = len_hi_r;
    remain_nxt = remain_r;
    res_vld    = 1'b0;
    res_data   = 8'd0;
    res_has    = 1'b0;
    res_last   = 1'b0;
    res_err    = 1'b0;
    unique case (state_r)
      ST_TYPE: begin
        type_nxt  = in_byte;
        state_nxt = ST_VER_HI;
      end
      ST_VER_HI: begin
        ver_hi_nxt = in_byte;
        state_nxt  = ST_VER_LO;
      end
      ST_VER_LO: begin
        if (ver_hi_r != VerMajor || in_byte < VerMinorLo || in_byte > VerMinorHi) begin
          state_nxt = ST_FAILED;
          res_vld   = 1'b1;
          res_err   = 1'b1;
        end else begin
          state_nxt = ST_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        len_hi_nxt = in_byte;
        state_nxt  = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        if (hdr_len > max_len_r) begin
          state_nxt = ST_FAILED;
          res_vld   = 1'b1;
          res_err   = 1'b1;
        end else if (hdr_len == 16'd0) begin
          state_nxt = ST_TYPE;
          res_vld   = 1'b1;
          res_last  = 1'b1;
        end else begin
          remain_nxt = hdr_len;
          state_nxt  = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        remain_nxt = remain_r - 16'd1;
        res_vld    = 1'b1;
        res_data   = in_byte;
        res_has    = 1'b1;
        res_last   = (remain_r == 16'd1);
        if (remain_r == 16'd1) begin
          state_nxt = ST_TYPE;
        end
      end
      ST_FAILED: begin
        state_nxt = ST_FAILED;
      end
      default: begin
        state_nxt = ST_FAILED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_TYPE;
      type_r   <= 8'd0;
      ver_hi_r <= 8'd0;
      len_hi_r <= 8'd0;
      remain_r <= 16'd0;
    end else if (in_fire) begin
      state_r  <= state_nxt;
      type_r   <= type_nxt;
      ver_hi_r <= ver_hi_nxt;
      len_hi_r <= len_hi_nxt;
      remain_r <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_fire && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_vld) begin
      out_type_r <= type_r;
      out_data_r <= res_data;
      out_has_r  <= res_has;
      out_last_r <= res_last;
      out_err_r  <= res_err;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_record_type    = out_type_r;
  assign out_data_byte      = out_data_r;
  assign out_has_data       = out_has_r;
  assign out_last_of_record = out_last_r;
  assign out_header_error   = out_err_r;

  a_err_means_failed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (state_r == ST_FAILED))
    else $error("error result without failed state");

  a_failed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FAILED && !out_valid_r) |=> !out_valid_r)
    else $error("result produced while failed");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAYLOAD) |-> (remain_r != 16'd0))
    else $error("payload state with zero bytes remaining");

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for tls_record_deframer_unit, directed records then random streams
// depends on tlsdf_pkg and the deframer rtl; a scoreboard class predicts each tagged fragment byte
module tb;
  import tlsdf_pkg::*;

  localparam logic [CfgAddrW-1:0] MaxLenAddr = '0;
  localparam int LongHold    = 80;
  localparam int StallLimit  = 2000;
  localparam int StreamItems = 1700;
  localparam int CalmItems   = 250;

  typedef struct packed {
    logic [7:0] rtype;
    logic [7:0] data;
    logic       has_data;
    logic       last;
    logic       err;
  } frag_t;

  class deframe_scoreboard;
    dfr_state_t  st;
    logic [7:0]  rtype;
    logic [7:0]  ver_hi;
    logic [7:0]  len_hi;
    logic [15:0] remaining;
    logic [15:0] max_len;
    frag_t       pending[$];
    int          errors;

    function new();
      st        = ST_TYPE;
      rtype     = '0;
      ver_hi    = '0;
      len_hi    = '0;
      remaining = '0;
      max_len   = MaxLenReset;
      errors    = 0;
    endfunction

    function void take_byte(logic [7:0] b);
      logic [15:0] len;
      case (st)
        ST_PAYLOAD: begin
          remaining = remaining - 16'd1;
          pending.push_back('{rtype, b, 1'b1, remaining == 16'd0, 1'b0});
          if (remaining == 16'd0) st = ST_TYPE;
        end
        ST_TYPE: begin
          rtype = b;
          st = ST_VER_HI;
        end
        ST_VER_HI: begin
          ver_hi = b;
          st = ST_VER_LO;
        end
        ST_VER_LO: begin
          if (ver_hi != VerMajor || b < VerMinorLo || b > VerMinorHi) begin
            st = ST_FAILED;
            pending.push_back('{rtype, 8'h00, 1'b0, 1'b0, 1'b1});
          end else begin
            st = ST_LEN_HI;
          end
        end
        ST_LEN_HI: begin
          len_hi = b;
          st = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          len = {len_hi, b};
          if (len > max_len) begin
            st = ST_FAILED;
            pending.push_back('{rtype, 8'h00, 1'b0, 1'b0, 1'b1});
          end else if (len == 16'd0) begin
            st = ST_TYPE;
            pending.push_back('{rtype, 8'h00, 1'b0, 1'b1, 1'b0});
          end else begin
            remaining = len;
            st = ST_PAYLOAD;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(frag_t got);
      frag_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual type %h data %h has %b last %b err %b",
                 $time, got.rtype, got.data, got.has_data, got.last, got.err);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch, expected type %h data %h has %b last %b err %b",
                 $time, want.rtype, want.data, want.has_data, want.last, want.err);
        $display("%0t:           actual type %h data %h has %b last %b err %b",
                 $time, got.rtype, got.data, got.has_data, got.last, got.err);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          in_byte;
  logic                out_valid;
  logic                out_ready;
  logic [7:0]          out_record_type;
  logic [7:0]          out_data_byte;
  logic                out_has_data;
  logic                out_last_of_record;
  logic                out_header_error;

  deframe_scoreboard sb;
  bit                tx_idle_on;
  bit                rx_idle_on;
  bit                hold_req;
  int                n_sent;
  int                quiet_cycles;

  tls_record_deframer_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_record_type   (out_record_type),
    .out_data_byte     (out_data_byte),
    .out_has_data      (out_has_data),
    .out_last_of_record(out_last_of_record),
    .out_header_error  (out_header_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result sampling and stall watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{out_record_type, out_data_byte, out_has_data,
                        out_last_of_record, out_header_error});
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("tls_record_deframer_unit regression: fail");
        $finish;
      end
    end
  end

  // receiver back-pressure
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_byte(b);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_header(input logic [7:0] rtype, input logic [7:0] major,
                             input logic [7:0] minor, input logic [15:0] len);
    send_byte(rtype);
    send_byte(major);
    send_byte(minor);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  task automatic send_record(input logic [7:0] rtype, input logic [7:0] minor,
                             input logic [15:0] len);
    send_header(rtype, VerMajor, minor, len);
    for (int i = 0; i < int'(len); i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_record();
    int cap;
    cap = ($urandom_range(0, 9) == 0) ? 300 : 24;
    if (cap > int'(sb.max_len)) cap = int'(sb.max_len);
    send_record(8'($urandom_range(0, 255)), 8'($urandom_range(VerMinorLo, VerMinorHi)),
                16'(($urandom_range(0, 7) == 0) ? cap : $urandom_range(0, cap)));
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write then read back, block idle
  task automatic cfg_set_max_len(input logic [15:0] v);
    wait_drained();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = MaxLenAddr;
    pwdata  = {16'h0000, v};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.max_len = v;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== v) begin
      sb.errors++;
      $display("%0t: max length read back, expected %h actual %h", $time, v, prdata[15:0]);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  initial begin
    logic [7:0]  major;
    logic [7:0]  minor;
    logic [15:0] len;
    int          recs_left;

    sb           = new();
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    in_byte      = '0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_req     = 1'b0;
    n_sent       = 0;
    quiet_cycles = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty record, single byte, version extremes, length at the limit
    send_record(8'h00, VerMinorLo, 16'd0);
    send_record(8'hff, VerMinorHi, 16'd1);
    cfg_set_max_len(16'd3);
    send_record(8'h17, 8'h03, 16'd3);
    cfg_set_max_len(16'd0);
    send_record(8'h16, 8'h02, 16'd0);
    cfg_set_max_len(16'hffff);
    send_record(8'h15, VerMinorHi, 16'h0100);

    // long receiver hold while the sender keeps offering, then a full drain
    hold_req = 1'b1;
    send_record(8'h17, 8'h03, 16'd40);
    wait_drained();
    send_record(8'h14, 8'h03, 16'd2);

    // random records, configuration changed between batches
    recs_left = 0;
    while (n_sent < StreamItems - CalmItems) begin
      if (recs_left == 0) begin
        case ($urandom_range(0, 4))
          0:       cfg_set_max_len(16'd0);
          1:       cfg_set_max_len(16'hffff);
          2:       cfg_set_max_len(16'($urandom_range(0, 65535)));
          default: cfg_set_max_len(16'($urandom_range(1, 30)));
        endcase
        recs_left = $urandom_range(10, 30);
      end
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      send_random_record();
      recs_left--;
    end

    // calm tail, no idling
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (n_sent < StreamItems) send_random_record();

    // one rejected header ends the stream for good
    if ($urandom_range(0, 1) == 0) begin
      major = VerMajor;
      minor = VerMinorLo;
      case ($urandom_range(0, 3))
        0:       minor = 8'h00;
        1:       minor = VerMinorHi + 8'd1;
        2:       minor = 8'($urandom_range(VerMinorHi + 1, 255));
        default: begin
          major = 8'($urandom_range(0, 255));
          if (major == VerMajor) major = major ^ 8'h80;
        end
      endcase
      send_header(8'($urandom_range(0, 255)), major, minor, 16'($urandom_range(0, 65535)));
    end else begin
      cfg_set_max_len(16'($urandom_range(0, 300)));
      len = ($urandom_range(0, 1) == 0) ? sb.max_len + 16'd1 : 16'hffff;
      send_header(8'($urandom_range(0, 255)), VerMajor,
                  8'($urandom_range(VerMinorLo, VerMinorHi)), len);
    end
    repeat (30) send_byte(8'($urandom_range(0, 255)));

    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tls_record_deframer_unit regression: pass");
    end else begin
      $display("tls_record_deframer_unit regression: fail");
    end
    $finish;
  end

endmodule
